// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/gmpp_pkg.sv =====
// Shared types, constants and functions of the marginal posterior peak block
`default_nettype none
package gmpp_pkg;
    localparam int GRID_RES_DEF = 64;
    localparam int IDX_W = 6;
    localparam int SUM_W = 44;
    localparam int CHI_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [CHI_W-1:0] LIK_SCALE = 32'd3098164010;

    localparam logic [CFG_IDX_W-1:0] REG_F_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_F_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_S_ORIGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_S_STEP   = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_RUN, ST_SCAN, ST_VALUE, ST_OUT
    } state_t;

    // 2^(-k/8) in Q0.32, k = 0..8
    function automatic logic [31:0] pow2_tab(input logic [3:0] k);
        logic [31:0] v;
        begin
            case (k)
                4'd0: v = 32'd4294967295;
                4'd1: v = 32'd3938502376;
                4'd2: v = 32'd3611622603;
                4'd3: v = 32'd3311872526;
                4'd4: v = 32'd3037000500;
                4'd5: v = 32'd2784941738;
                4'd6: v = 32'd2553802834;
                4'd7: v = 32'd2341847523;
                default: v = 32'd2147483648;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/gmpp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module gmpp_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/gmpp_lik.sv =====
// Pipeline turning chi-square into a Q0.32 likelihood; the scaled product is registered
`default_nettype none
module gmpp_lik (
    input  wire logic        aclk,
    input  wire logic [31:0] chisq,
    output logic      [31:0] lik
);
    logic [63:0] prod;
    logic [31:0] t_reg;
    logic [3:0]  k;
    logic [12:0] r;
    logic [15:0] n;
    logic [31:0] ta, tb, d;
    logic [44:0] dr;
    logic [31:0] v;

    assign prod = 64'(chisq) * 64'(gmpp_pkg::LIK_SCALE);

    always_ff @(posedge aclk) begin
        t_reg <= prod[63:32];
    end

    assign n  = t_reg[31:16];
    assign k  = {1'b0, t_reg[15:13]};
    assign r  = t_reg[12:0];
    assign ta = gmpp_pkg::pow2_tab(k);
    assign tb = gmpp_pkg::pow2_tab(k + 4'd1);
    assign d  = ta - tb;
    assign dr = 45'(d) * 45'(r);
    assign v  = ta - dr[44:13];

    always_comb begin
        if (n >= 16'd32) begin
            lik = '0;
        end else begin
            lik = v >> n[4:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/grid_marginal_posterior_peak_top.sv =====
// Top level: marginal accumulation, running minimum and peak scan
//
//  channel | valid/ready           | payload
//  s_      | s_valid / s_ready     | indices, chisq, is_final
//  m_      | m_valid / m_ready     | peak, least and best values
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each point passes through a likelihood stage, a RAM read and a write back before the
// next is taken; the one-port read-modify-write of the marginal RAMs sets this.
// A final point adds a scan of the marginal RAMs, the value math and a step to load
// the result; the value math waits while an earlier result is still held.
// After reset and after each result a clearing pass over the GRID_RES addresses runs.
// A result waits in its output register until m_ready.
`default_nettype none
`include "assert_macros.svh"
module grid_marginal_posterior_peak_top #(
    parameter int GRID_RES = gmpp_pkg::GRID_RES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [5:0]  s_f_index,
    input  wire logic [5:0]  s_b_index,
    input  wire logic [5:0]  s_s_index,
    input  wire logic [31:0] s_chisq,
    input  wire logic        s_is_final,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_peak_f_value,
    output logic [31:0]      m_peak_b_value,
    output logic [31:0]      m_peak_s_value,
    output logic [31:0]      m_least_chisq,
    output logic [31:0]      m_best_f_value,
    output logic [31:0]      m_best_b_value,
    output logic [31:0]      m_best_s_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int RAW = $clog2(GRID_RES);
    localparam int CW = RAW + 1;
    localparam logic [CW-1:0] LAST = CW'(GRID_RES - 1);
    localparam logic [43:0] SUM_MAX = '1;

    // registers
    logic [31:0] cfg_reg [6];

    gmpp_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    ph_reg, ph_next;
    logic [5:0]  fi_reg, bi_reg, si_reg;
    logic        fin_reg, inr_reg;
    logic [31:0] chi_reg;
    logic [31:0] min_reg;
    logic [17:0] mini_reg;
    logic [43:0] bestv_reg [3];
    logic [5:0]  besti_reg [3];
    logic [CW-1:0] scan_addr_reg;
    logic        scan_vld_reg;
    logic [1:0]  vph_reg;
    logic [31:0] out_reg [7];
    logic        mv_reg;

    logic [31:0] lik;
    logic [43:0] rd [3];
    logic        we;
    logic [RAW-1:0] wa [3];
    logic [RAW-1:0] ra [3];
    logic [43:0] wd [3];
    logic        in_range;

    gmpp_lik u_lik (.aclk(aclk), .chisq(chi_reg), .lik(lik));

    assign in_range = (32'(s_f_index) < GRID_RES) && (32'(s_b_index) < GRID_RES)
                   && (32'(s_s_index) < GRID_RES);

    // per-axis addresses and write data
    always_comb begin
        logic [5:0] ix [3];
        logic [44:0] s;
        ix[0] = fi_reg; ix[1] = bi_reg; ix[2] = si_reg;
        we = 1'b0;
        for (int a = 0; a < 3; a++) begin
            s = 45'(rd[a]) + 45'(lik);
            if (state_reg == gmpp_pkg::ST_CLEAR) begin
                wa[a] = cnt_reg[RAW-1:0];
                wd[a] = '0;
            end else begin
                wa[a] = RAW'(ix[a]);
                wd[a] = s[44] ? SUM_MAX : s[43:0];
            end
            if (state_reg == gmpp_pkg::ST_SCAN) begin
                ra[a] = cnt_reg[RAW-1:0];
            end else begin
                ra[a] = RAW'(ix[a]);
            end
        end
        if (state_reg == gmpp_pkg::ST_CLEAR) begin
            we = 1'b1;
        end else if (state_reg == gmpp_pkg::ST_RUN && ph_reg == 2'd2 && inr_reg) begin
            we = 1'b1;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_ram
        gmpp_ram #(.WIDTH(44), .DEPTH(GRID_RES)) u_ram (
            .aclk(aclk), .wr_en(we), .wr_addr(wa[g]), .wr_data(wd[g]),
            .rd_addr(ra[g]), .rd_data(rd[g])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        case (state_reg)
            gmpp_pkg::ST_CLEAR: begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST) begin
                    state_next = gmpp_pkg::ST_RUN;
                    cnt_next = '0;
                end
            end
            gmpp_pkg::ST_RUN: begin
                if (ph_reg == 2'd0) begin
                    if (s_valid) ph_next = 2'd1;
                end else if (ph_reg == 2'd1) begin
                    ph_next = 2'd2;
                end else begin
                    ph_next = 2'd0;
                    if (fin_reg) begin
                        state_next = gmpp_pkg::ST_SCAN;
                        cnt_next = '0;
                    end
                end
            end
            gmpp_pkg::ST_SCAN: begin
                if (cnt_reg != CW'(GRID_RES)) cnt_next = cnt_reg + CW'(1);
                // hold until the previous result has left the output register
                if (!scan_vld_reg && cnt_reg == CW'(GRID_RES) && !mv_reg) begin
                    state_next = gmpp_pkg::ST_VALUE;
                end
            end
            gmpp_pkg::ST_VALUE: begin
                if (vph_reg == 2'd2) state_next = gmpp_pkg::ST_OUT;
            end
            gmpp_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    state_next = gmpp_pkg::ST_CLEAR;
                    cnt_next = '0;
                end
            end
            default: state_next = gmpp_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = (state_reg == gmpp_pkg::ST_RUN) && (ph_reg == 2'd0);
        cfg_ready = 1'b1;
    end

    // saturated origin + step * index
    function automatic logic [31:0] axis_val(input logic [31:0] org, input logic [31:0] stp,
                                             input logic [5:0] ix);
        logic signed [39:0] p;
        logic signed [40:0] v;
        begin
            p = 40'(signed'(stp)) * signed'({34'd0, ix});
            v = 41'(signed'(org)) + 41'(p);
            if (v > 41'sd2147483647) return 32'h7FFFFFFF;
            if (v < -41'sd2147483648) return 32'h80000000;
            return v[31:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gmpp_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            ph_reg    <= '0;
            mv_reg    <= 1'b0;
            min_reg   <= '1;
            mini_reg  <= '0;
            scan_vld_reg <= 1'b0;
            vph_reg   <= '0;
            fin_reg   <= 1'b0;
            inr_reg   <= 1'b0;
            cfg_reg[0] <= '0; cfg_reg[1] <= 32'd65536;
            cfg_reg[2] <= '0; cfg_reg[3] <= 32'd65536;
            cfg_reg[4] <= '0; cfg_reg[5] <= 32'd65536;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
            if (cfg_valid && cfg_ready && cfg_index <= gmpp_pkg::REG_S_STEP) begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (s_valid && s_ready) begin
                fi_reg  <= s_f_index;
                bi_reg  <= s_b_index;
                si_reg  <= s_s_index;
                chi_reg <= s_chisq;
                fin_reg <= s_is_final;
                inr_reg <= in_range;
                if (in_range && s_chisq < min_reg) begin
                    min_reg  <= s_chisq;
                    mini_reg <= {s_f_index, s_b_index, s_s_index};
                end
            end
            // scan: read address cnt, compare in the following cycle
            scan_vld_reg <= (state_reg == gmpp_pkg::ST_SCAN) && (cnt_reg != CW'(GRID_RES));
            scan_addr_reg <= cnt_reg;
            if (state_reg == gmpp_pkg::ST_SCAN && scan_vld_reg) begin
                for (int a = 0; a < 3; a++) begin
                    if (scan_addr_reg == '0 || rd[a] > bestv_reg[a]) begin
                        bestv_reg[a] <= rd[a];
                        besti_reg[a] <= 6'(scan_addr_reg);
                    end
                end
            end
            if (state_reg == gmpp_pkg::ST_VALUE) begin
                vph_reg <= vph_reg + 2'd1;
                case (vph_reg)
                    2'd0: begin
                        out_reg[0] <= axis_val(cfg_reg[0], cfg_reg[1], besti_reg[0]);
                        out_reg[1] <= axis_val(cfg_reg[2], cfg_reg[3], besti_reg[1]);
                        out_reg[2] <= axis_val(cfg_reg[4], cfg_reg[5], besti_reg[2]);
                    end
                    2'd1: begin
                        out_reg[3] <= min_reg;
                        out_reg[4] <= axis_val(cfg_reg[0], cfg_reg[1], mini_reg[17:12]);
                        out_reg[5] <= axis_val(cfg_reg[2], cfg_reg[3], mini_reg[11:6]);
                        out_reg[6] <= axis_val(cfg_reg[4], cfg_reg[5], mini_reg[5:0]);
                    end
                    default: ;
                endcase
            end else begin
                vph_reg <= '0;
            end
            if (state_reg == gmpp_pkg::ST_OUT && (!mv_reg || m_ready)) begin
                mv_reg   <= 1'b1;
                min_reg  <= '1;
                mini_reg <= '0;
            end else if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = mv_reg;
    assign m_peak_f_value = out_reg[0];
    assign m_peak_b_value = out_reg[1];
    assign m_peak_s_value = out_reg[2];
    assign m_least_chisq  = out_reg[3];
    assign m_best_f_value = out_reg[4];
    assign m_best_b_value = out_reg[5];
    assign m_best_s_value = out_reg[6];

    `ASSERT_IMPL(a_ready_run, aclk, aresetn, s_ready, state_reg == gmpp_pkg::ST_RUN,
                 "ready outside run")
    `ASSERT_NEXT(a_accept_ph, aclk, aresetn, s_valid && s_ready, ph_reg == 2'd1, "phase slip")
    `ASSERT_IMPL(a_clear_we, aclk, aresetn, state_reg == gmpp_pkg::ST_CLEAR, we && !s_ready,
                 "clear pass")
endmodule
`default_nettype wire
